FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the button press classifier checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define BPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpc assertion failed");

// clocked assertion that also holds during reset
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bpc assertion failed");

`endif

FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// types and constants for the button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_MS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_WINDOW_MS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LOW       = 2'd3;

   localparam logic [31:0] DEBOUNCE_MS_RESET      = 32'd50;
   localparam logic [31:0] LONG_PRESS_MS_RESET    = 32'd1000;
   localparam logic [31:0] DOUBLE_WINDOW_MS_RESET = 32'd400;
   localparam logic        ACTIVE_LOW_RESET       = 1'b1;

   localparam logic [1:0] GESTURE_NONE   = 2'd0;
   localparam logic [1:0] GESTURE_SINGLE = 2'd1;
   localparam logic [1:0] GESTURE_DOUBLE = 2'd2;
   localparam logic [1:0] GESTURE_LONG   = 2'd3;

   localparam logic [31:0] NO_RELEASE_MS = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        raw_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        down_event;
      logic        up_event;
      logic [1:0]  gesture;
      logic [31:0] gesture_ms;
      logic        is_down;
      logic [31:0] last_state_ms;
   } rsp_type;

   typedef struct packed {
      logic                   wr_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_wr_type;

endpackage

FILE: rtl/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core
// configuration registers, debounce and gesture state, per-beat result logic
// ----------------------------------------------------------------------------
module bpc_core (
   input  logic                clock,
   input  logic                reset,
   input  bpc_pkg::csr_wr_type csr,
   input  logic                step,
   input  bpc_pkg::req_type    req,
   output bpc_pkg::rsp_type    rsp
);
   import bpc_pkg::*;

   logic [31:0] debounce_ff, long_ff, window_ff;
   logic        active_low_ff;

   logic        raw_seen_ff, raw_seen_in;
   logic [31:0] change_time_ff, change_time_in;
   logic        stable_ff, stable_in;
   logic [31:0] entered_ff, entered_in;
   logic [31:0] prev_dur_ff, prev_dur_in;
   logic [31:0] prev_rel_ff, prev_rel_in;
   logic        prev_rel_valid_ff, prev_rel_valid_in;
   logic        handled_ff, handled_in;

   logic        level;
   logic [31:0] since;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_MS_RESET;
         long_ff       <= LONG_PRESS_MS_RESET;
         window_ff     <= DOUBLE_WINDOW_MS_RESET;
         active_low_ff <= ACTIVE_LOW_RESET;
      end else if (csr.wr_en) begin
         unique case (csr.index)
            CSR_DEBOUNCE_MS:      debounce_ff   <= csr.wdata;
            CSR_LONG_PRESS_MS:    long_ff       <= csr.wdata;
            CSR_DOUBLE_WINDOW_MS: window_ff     <= csr.wdata;
            CSR_ACTIVE_LOW:       active_low_ff <= csr.wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      level             = req.raw_level ^ active_low_ff;
      raw_seen_in       = raw_seen_ff;
      change_time_in    = change_time_ff;
      stable_in         = stable_ff;
      entered_in        = entered_ff;
      prev_dur_in       = prev_dur_ff;
      prev_rel_in       = prev_rel_ff;
      prev_rel_valid_in = prev_rel_valid_ff;
      handled_in        = handled_ff;
      rsp               = '0;

      if (level != raw_seen_ff) begin
         raw_seen_in    = level;
         change_time_in = req.now_ms;
      end

      if ((req.now_ms - change_time_in) > debounce_ff && level != stable_ff) begin
         prev_dur_in = req.now_ms - entered_ff;
         entered_in  = req.now_ms;
         stable_in   = level;
         handled_in  = 1'b0;
         if (level) begin
            // start of the released period that just ended
            prev_rel_in       = entered_ff;
            prev_rel_valid_in = 1'b1;
            rsp.down_event    = 1'b1;
         end else begin
            rsp.up_event = 1'b1;
         end
      end

      since = prev_rel_valid_in ? (req.now_ms - prev_rel_in) : NO_RELEASE_MS;

      if (!handled_in && !stable_in) begin
         if (prev_dur_in >= long_ff) begin
            handled_in     = 1'b1;
            rsp.gesture    = GESTURE_LONG;
            rsp.gesture_ms = prev_dur_in;
         end else if (since < window_ff && prev_dur_in != '0) begin
            handled_in        = 1'b1;
            prev_rel_valid_in = 1'b0;
            rsp.gesture       = GESTURE_DOUBLE;
            rsp.gesture_ms    = since;
         end else if (prev_dur_in != '0) begin
            handled_in     = 1'b1;
            rsp.gesture    = GESTURE_SINGLE;
            rsp.gesture_ms = prev_dur_in;
         end
      end

      rsp.is_down       = stable_in;
      rsp.last_state_ms = prev_dur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff       <= 1'b0;
         change_time_ff    <= '0;
         stable_ff         <= 1'b0;
         entered_ff        <= '0;
         prev_dur_ff       <= '0;
         prev_rel_ff       <= '0;
         prev_rel_valid_ff <= 1'b0;
         handled_ff        <= 1'b1;
      end else if (step) begin
         raw_seen_ff       <= raw_seen_in;
         change_time_ff    <= change_time_in;
         stable_ff         <= stable_in;
         entered_ff        <= entered_in;
         prev_dur_ff       <= prev_dur_in;
         prev_rel_ff       <= prev_rel_in;
         prev_rel_valid_ff <= prev_rel_valid_in;
         handled_ff        <= handled_in;
      end
   end

endmodule

FILE: rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// debounced push button with press, release and gesture reporting
// ----------------------------------------------------------------------------
// a result is registered in rsp_ff, or in skid_ff past a stalled output
// throughput: one beat per cycle while req_stall is low; the state update closes in that cycle
// a two-entry result buffer takes one beat past a stalled output, then
// req_stall holds until the output takes a beat
// reset: synchronous; restores register defaults and clears button state
// ----------------------------------------------------------------------------
module button_press_classifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bpc_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bpc_pkg::rsp_type                      rsp_payload,
   input  logic                                  csr_wr_en,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import bpc_pkg::*;

   csr_wr_type csr;
   rsp_type    result;
   rsp_type    rsp_ff, skid_ff;
   logic       rsp_valid_ff, skid_valid_ff;
   logic       accept, take;

   assign csr    = '{wr_en: csr_wr_en, index: csr_index, wdata: csr_wdata};
   assign accept = req_valid && !req_stall;
   assign take   = rsp_valid_ff && !rsp_stall;

   bpc_core u_core (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .step  (accept),
      .req   (req_payload),
      .rsp   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_ff       <= result;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall   = skid_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// port-level checks for the button press classifier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpc_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  bpc_pkg::rsp_type                      rsp_payload
);
   import bpc_pkg::*;

   `BPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `BPC_ASSERT(a_one_edge, clock, reset, rsp_valid |-> !(rsp_payload.down_event && rsp_payload.up_event))
   `BPC_ASSERT(a_edge_state, clock, reset, rsp_valid && rsp_payload.down_event |-> rsp_payload.is_down)
   `BPC_ASSERT(a_gesture_released, clock, reset, rsp_valid && rsp_payload.gesture != GESTURE_NONE |-> !rsp_payload.is_down)
   `BPC_ASSERT(a_none_zero_ms, clock, reset, rsp_valid && rsp_payload.gesture == GESTURE_NONE |-> rsp_payload.gesture_ms == '0)

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the button press classifier beat by beat against a local model of
// its debounce and gesture logic, with directed press patterns, random press
// sequences under several register settings and random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
   import bpc_pkg::*;

   class gesture_scoreboard;
      logic [31:0] debounce_ms;
      logic [31:0] long_press_ms;
      logic [31:0] double_window_ms;
      logic        active_low;
      logic        raw_seen;
      logic        is_down;
      logic        release_valid;
      logic        handled;
      logic [31:0] change_ms;
      logic [31:0] entered_ms;
      logic [31:0] held_ms;
      logic [31:0] release_ms;
      rsp_type     expected_events[$];
      int          mismatch_count;

      function new();
         debounce_ms      = DEBOUNCE_MS_RESET;
         long_press_ms    = LONG_PRESS_MS_RESET;
         double_window_ms = DOUBLE_WINDOW_MS_RESET;
         active_low       = ACTIVE_LOW_RESET;
         raw_seen         = 1'b0;
         is_down          = 1'b0;
         release_valid    = 1'b0;
         handled          = 1'b1;
         change_ms        = '0;
         entered_ms       = '0;
         held_ms          = '0;
         release_ms       = '0;
         mismatch_count   = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_DEBOUNCE_MS:      debounce_ms = data;
            CSR_LONG_PRESS_MS:    long_press_ms = data;
            CSR_DOUBLE_WINDOW_MS: double_window_ms = data;
            CSR_ACTIVE_LOW:       active_low = data[0];
            default: ;
         endcase
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         mismatch_count++;
      endtask

      function rsp_type classify_sample(req_type beat);
         rsp_type     r;
         logic        level;
         logic [31:0] now;
         logic [31:0] stable_for;
         logic [31:0] since;
         r = '0;
         level = beat.raw_level ^ active_low;
         now = beat.now_ms;
         if (level != raw_seen) begin
            raw_seen = level;
            change_ms = now;
         end
         stable_for = now - change_ms;
         if (stable_for > debounce_ms && level != is_down) begin
            held_ms = now - entered_ms;
            entered_ms = now;
            is_down = level;
            handled = 1'b0;
            if (is_down) begin
               release_ms = now - held_ms;
               release_valid = 1'b1;
               r.down_event = 1'b1;
            end else begin
               r.up_event = 1'b1;
            end
         end
         if (!handled && !is_down) begin
            since = release_valid ? now - release_ms : NO_RELEASE_MS;
            if (held_ms >= long_press_ms) begin
               handled = 1'b1;
               r.gesture = GESTURE_LONG;
               r.gesture_ms = held_ms;
            end else if (since < double_window_ms && held_ms != 0) begin
               handled = 1'b1;
               release_valid = 1'b0;
               r.gesture = GESTURE_DOUBLE;
               r.gesture_ms = since;
            end else if (held_ms != 0 && since >= double_window_ms) begin
               handled = 1'b1;
               r.gesture = GESTURE_SINGLE;
               r.gesture_ms = held_ms;
            end
         end
         r.is_down = is_down;
         r.last_state_ms = held_ms;
         return r;
      endfunction

      function void note_sample(req_type beat);
         expected_events.push_back(classify_sample(beat));
      endfunction

      task check_event(rsp_type got);
         rsp_type want;
         string   bad;
         if (expected_events.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = expected_events.pop_front();
         bad = "";
         if (got.down_event !== want.down_event) bad = {bad, " down_event"};
         if (got.up_event !== want.up_event) bad = {bad, " up_event"};
         if (got.gesture !== want.gesture) bad = {bad, " gesture"};
         if (got.gesture_ms !== want.gesture_ms) bad = {bad, " gesture_ms"};
         if (got.is_down !== want.is_down) bad = {bad, " is_down"};
         if (got.last_state_ms !== want.last_state_ms) bad = {bad, " last_state_ms"};
         if (bad != "") begin
            report($sformatf("wrong%s: got %h want %h", bad, got, want));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   gesture_scoreboard sb = new();

   int          tx_idle_pct = 13;
   int          rx_idle_pct = 55;
   logic        level_flip = ACTIVE_LOW_RESET;
   logic        want_down;
   logic [31:0] stamp;
   int          hold_ms;

   button_press_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_sample(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_event(rsp_payload);
      end
   end

   // called and returns at a falling edge
   task automatic send_beat(req_type beat);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      @(negedge clock);
   endtask

   task automatic wait_idle(int settle);
      req_valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      sb.set_reg(index, data);
      @(negedge clock);
   endtask

   task automatic configure(logic [31:0] debounce, logic [31:0] long_ms,
                            logic [31:0] window, logic low);
      wait_idle(4);
      write_reg(CSR_DEBOUNCE_MS, debounce);
      write_reg(CSR_LONG_PRESS_MS, long_ms);
      write_reg(CSR_DOUBLE_WINDOW_MS, window);
      write_reg(CSR_ACTIVE_LOW, {31'd0, low});
      csr_wr_en <= 1'b0;
      level_flip = low;
   endtask

   // press sequences with bounces, plus a few random jumps in time and level
   task automatic random_run(int count, int step_max, int press_max, int gap_max,
                             logic [31:0] start);
      req_type s;
      int      pick;
      int      step;
      stamp = start;
      want_down = 1'b0;
      hold_ms = 0;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            stamp = $urandom;
            s.raw_level = 1'($urandom_range(0, 1));
         end else begin
            step = $urandom_range(0, step_max);
            stamp = stamp + step;
            hold_ms = hold_ms - step;
            if (hold_ms < 0) begin
               want_down = !want_down;
               hold_ms = want_down ? $urandom_range(0, press_max) : $urandom_range(0, gap_max);
            end
            s.raw_level = (pick < 10) ? ((!want_down) ^ level_flip) : (want_down ^ level_flip);
         end
         s.now_ms = stamp;
         send_beat(s);
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, active low: raw 0 is pressed
      send_beat('{1'b1, 32'd0});
      send_beat('{1'b0, 32'd10});
      send_beat('{1'b0, 32'd60});
      send_beat('{1'b0, 32'd61});
      send_beat('{1'b1, 32'd200});
      send_beat('{1'b1, 32'd251});
      send_beat('{1'b0, 32'd300});
      send_beat('{1'b0, 32'd351});
      send_beat('{1'b1, 32'd1500});
      send_beat('{1'b1, 32'd1551});
      send_beat('{1'b0, 32'd2000});
      send_beat('{1'b0, 32'd2051});
      send_beat('{1'b1, 32'd2100});
      send_beat('{1'b1, 32'd2151});
      // zero-length press: release edge at the press timestamp
      send_beat('{1'b0, 32'd3000});
      send_beat('{1'b0, 32'd3051});
      send_beat('{1'b1, 32'd2900});
      send_beat('{1'b1, 32'd3051});
      // bounce, then press and release across the timestamp wrap
      send_beat('{1'b0, 32'd4000});
      send_beat('{1'b1, 32'd4010});
      send_beat('{1'b0, 32'd4020});
      send_beat('{1'b0, 32'd4071});
      send_beat('{1'b1, 32'hFFFF_FF00});
      send_beat('{1'b1, 32'hFFFF_FF40});
      send_beat('{1'b0, 32'hFFFF_FFF0});
      send_beat('{1'b0, 32'h0000_0030});
      send_beat('{1'b1, 32'h0000_0100});
      send_beat('{1'b1, 32'h0000_0140});

      configure(32'd20, 32'd300, 32'd200, 1'b0);
      random_run(170, 25, 500, 300, $urandom);
      configure(32'd0, 32'd0, 32'd0, 1'b1);
      random_run(150, 4, 10, 10, 32'hFFFF_FF00);

      tx_idle_pct = 55;
      rx_idle_pct = 13;
      configure(32'd5, 32'd40, 32'd30, 1'b1);
      random_run(170, 8, 70, 50, $urandom);
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      random_run(40, 1000, 3000, 3000, $urandom);
      configure(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      random_run(120, 3, 12, 12, $urandom);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      configure(DEBOUNCE_MS_RESET, LONG_PRESS_MS_RESET, DOUBLE_WINDOW_MS_RESET,
                ACTIVE_LOW_RESET);
      random_run(200, 60, 1500, 700, $urandom);
      configure(32'd1, 32'd12, 32'd9, 1'b0);
      random_run(150, 3, 20, 14, $urandom);

      wait_idle(10);
      if (sb.mismatch_count == 0) begin
         $display("[button_press_classifier] OK");
      end else begin
         $display("[button_press_classifier] ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("[button_press_classifier] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_core.sv
rtl/button_press_classifier.sv
rtl/bpc_checker.sv
tb/testbench.sv
